[design/spq_pkg.sv]
// Shared types and constants for the sorted priority queue.
// Used by spq_cell, sorted_priority_queue, spq_checker and the testbench; depends on nothing.
package spq_pkg;

   localparam int KEY_W = 31;

   // Operation codes carried on req_tuser
   localparam logic KIND_INSERT = 1'b0;
   localparam logic KIND_POP    = 1'b1;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      OP_HOLD,
      OP_INSERT,
      OP_POP
   } cell_op_type;

   // Command broadcast to every cell of the row
   typedef struct packed {
      cell_op_type      op;
      logic [KEY_W-1:0] key;
   } cell_cmd_type;

endpackage

[design/spq_cell.sv]
// One slot of the sorted row: holds a key, compares it against an incoming
// key and shifts toward its neighbors. Depends on spq_pkg.
module spq_cell (
   input  logic                      clock,
   input  spq_pkg::cell_cmd_type     cmd,
   input  logic                      occupied,
   input  logic                      left_le,
   input  logic [spq_pkg::KEY_W-1:0] left_key,
   input  logic [spq_pkg::KEY_W-1:0] right_key,
   output logic                      le,
   output logic [spq_pkg::KEY_W-1:0] key_ff
);

   logic [spq_pkg::KEY_W-1:0] key_in;

   // Stored key is at or below the new key: it stays ahead of it
   assign le = occupied && (key_ff <= cmd.key);

   always_comb begin
      key_in = key_ff;
      case (cmd.op)
         spq_pkg::OP_INSERT: begin
            if (le) begin
               key_in = key_ff;
            end else if (left_le) begin
               key_in = cmd.key;
            end else begin
               key_in = left_key;
            end
         end
         spq_pkg::OP_POP: begin
            key_in = right_key;
         end
         default: begin
            key_in = key_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
   end

endmodule

[design/sorted_priority_queue.sv]
// Sorted priority queue: a row of DEPTH cells keeps the keys in ascending
// order. Each beat on req inserts req_tdata (req_tuser = 0) or pops the
// smallest key (req_tuser = 1) and yields exactly one rsp beat with status,
// key and occupancy. One item is taken every cycle unless rsp stalls:
// all cells compare against the new key and shift in the same cycle, and
// the result appears in the output register on the next cycle. Equal keys
// leave in arrival order. Depends on spq_pkg and spq_cell.
module sorted_priority_queue #(
   parameter int DEPTH = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic req_tuser,       // kind
   input  logic [31:0] req_tdata, // value[30:0], zero pad
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // status[1:0], key_out[32:2], occupancy above, zero pad
   output logic [((2 + spq_pkg::KEY_W + $clog2(DEPTH + 1) + 7) / 8) * 8 - 1:0] rsp_tdata
);

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int RSP_BITS = 2 + spq_pkg::KEY_W + CNT_W;
   localparam int RSP_W = ((RSP_BITS + 7) / 8) * 8;

   logic [CNT_W-1:0]          count_ff, count_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   spq_pkg::status_type       status_ff, status_in;
   logic [spq_pkg::KEY_W-1:0] key_out_ff, key_out_in;

   spq_pkg::cell_cmd_type     cmd;
   logic                      accept;
   logic                      full;
   logic                      empty;
   logic [spq_pkg::KEY_W-1:0] cell_key [DEPTH];
   logic [DEPTH-1:0]          cell_le;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign full       = (count_ff == CNT_W'(DEPTH));
   assign empty      = (count_ff == '0);

   always_comb begin
      cmd.key = req_tdata[spq_pkg::KEY_W-1:0];
      cmd.op  = spq_pkg::OP_HOLD;
      if (accept) begin
         if (req_tuser == spq_pkg::KIND_INSERT) begin
            if (!full) begin
               cmd.op = spq_pkg::OP_INSERT;
            end
         end else if (!empty) begin
            cmd.op = spq_pkg::OP_POP;
         end
      end
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic                      left_le;
      logic [spq_pkg::KEY_W-1:0] left_key;
      logic [spq_pkg::KEY_W-1:0] right_key;

      if (i == 0) begin : g_first
         assign left_le  = 1'b1;
         assign left_key = cmd.key;
      end else begin : g_inner
         assign left_le  = cell_le[i-1];
         assign left_key = cell_key[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign right_key = cell_key[i];
      end else begin : g_body
         assign right_key = cell_key[i+1];
      end

      spq_cell u_cell (
         .clock     (clock),
         .cmd       (cmd),
         .occupied  (count_ff > CNT_W'(i)),
         .left_le   (left_le),
         .left_key  (left_key),
         .right_key (right_key),
         .le        (cell_le[i]),
         .key_ff    (cell_key[i])
      );
   end

   always_comb begin
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff;
      status_in    = status_ff;
      key_out_in   = key_out_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (accept) begin
         rsp_valid_in = 1'b1;
         key_out_in   = '0;
         status_in    = spq_pkg::ST_OK;
         case (cmd.op)
            spq_pkg::OP_INSERT: begin
               count_in = count_ff + CNT_W'(1);
            end
            spq_pkg::OP_POP: begin
               count_in   = count_ff - CNT_W'(1);
               key_out_in = cell_key[0];
            end
            default: begin
               // refused beat: queue unchanged
               status_in = (req_tuser == spq_pkg::KIND_INSERT) ?
                           spq_pkg::ST_FULL : spq_pkg::ST_EMPTY;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      status_ff  <= status_in;
      key_out_ff <= key_out_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'({count_ff, key_out_ff, status_ff});

endmodule

[dv/spq_checker.sv]
// Scoreboard for the sorted priority queue: watches the req and rsp streams,
// predicts each result from its own sorted copy of the keys and compares.
// Depends on spq_pkg.
module spq_checker
   import spq_pkg::*;
#(
   parameter int DEPTH = 16,
   parameter int RSP_W = 40
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   input  logic             req_tready,
   input  logic             req_tuser,   // kind
   input  logic [31:0]      req_tdata,   // value[30:0], zero pad
   input  logic             rsp_tvalid,
   input  logic             rsp_tready,
   input  logic [RSP_W-1:0] rsp_tdata,   // status, key_out, occupancy, zero pad
   output int               fail_count,
   output int               pending,
   output int               refused_count,
   output int               underflow_count
);

   localparam int OCC_W = $clog2(DEPTH + 1);

   typedef struct packed {
      status_type       status;
      logic [KEY_W-1:0] key;
      logic [OCC_W-1:0] occ;
   } outcome_type;

   logic [KEY_W-1:0] queue_keys [DEPTH];
   int               queue_len;
   outcome_type      pending_outcomes [$];
   int               fails;
   int               refused;
   int               underflows;

   // Apply one item to the shadow queue and return the result it must produce.
   function automatic outcome_type predict_outcome(input logic kind,
                                                   input logic [KEY_W-1:0] key);
      outcome_type res;
      int          slot;
      res.status = ST_OK;
      res.key    = '0;
      if (kind == KIND_INSERT) begin
         if (queue_len >= DEPTH) begin
            res.status = ST_FULL;
         end else begin
            // equal keys go behind the ones already stored
            slot = 0;
            while (slot < queue_len && queue_keys[slot] <= key) slot++;
            for (int i = queue_len; i > slot; i--) queue_keys[i] = queue_keys[i - 1];
            queue_keys[slot] = key;
            queue_len++;
         end
      end else if (queue_len == 0) begin
         res.status = ST_EMPTY;
      end else begin
         res.key = queue_keys[0];
         for (int i = 1; i < queue_len; i++) queue_keys[i - 1] = queue_keys[i];
         queue_len--;
      end
      res.occ = queue_len[OCC_W-1:0];
      return res;
   endfunction

   task automatic report_field(input string name, input longint exp_val,
                               input longint act_val);
      if (exp_val != act_val) begin
         $display("%0t: rsp %s mismatch: expected %0d, actual %0d",
                  $time, name, exp_val, act_val);
         fails++;
      end
   endtask

   always @(posedge clock) begin
      outcome_type exp_res;
      outcome_type act_res;
      if (reset) begin
         queue_len  = 0;
         fails      = 0;
         refused    = 0;
         underflows = 0;
         pending_outcomes.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            act_res.status = status_type'(rsp_tdata[1:0]);
            act_res.key    = rsp_tdata[KEY_W+1:2];
            act_res.occ    = rsp_tdata[KEY_W+OCC_W+1:KEY_W+2];
            if (pending_outcomes.size() == 0) begin
               $display("%0t: unexpected rsp beat: expected none, actual status %0d key %0d occ %0d",
                        $time, act_res.status, act_res.key, act_res.occ);
               fails++;
            end else begin
               exp_res = pending_outcomes.pop_front();
               report_field("status", exp_res.status, act_res.status);
               report_field("key", exp_res.key, act_res.key);
               report_field("occupancy", exp_res.occ, act_res.occ);
               if (exp_res.status == ST_FULL) refused++;
               if (exp_res.status == ST_EMPTY) underflows++;
            end
         end
         if (req_tvalid && req_tready)
            pending_outcomes.push_back(predict_outcome(req_tuser, req_tdata[KEY_W-1:0]));
      end
      fail_count      <= fails;
      pending         <= pending_outcomes.size();
      refused_count   <= refused;
      underflow_count <= underflows;
   end

endmodule

[dv/tb_sorted_priority_queue.sv]
// Top of the sorted priority queue testbench: clock, reset, req/rsp stimulus
// with random idling, watchdog and verdict. Depends on spq_pkg, spq_checker
// and sorted_priority_queue.
module tb_sorted_priority_queue;
   import spq_pkg::*;

   localparam int DEPTH        = 16;
   localparam int RSP_W        = ((2 + KEY_W + $clog2(DEPTH + 1) + 7) / 8) * 8;
   localparam int RANDOM_ITEMS = 1000;
   localparam int STALL_LIMIT  = 5000;

   logic             clock      = 1'b0;
   logic             reset      = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic             req_tuser  = KIND_INSERT;  // kind
   logic [31:0]      req_tdata  = '0;           // value[30:0], zero pad
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;                 // status, key_out, occupancy, zero pad

   int fail_count;
   int pending;
   int refused_count;
   int underflow_count;
   int quiet_cycles = 0;
   bit steady       = 1'b0;
   int inserts_sent = 0;
   int pops_sent    = 0;

   sorted_priority_queue #(.DEPTH(DEPTH)) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   spq_checker #(.DEPTH(DEPTH), .RSP_W(RSP_W)) u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tuser       (req_tuser),
      .req_tdata       (req_tdata),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .fail_count      (fail_count),
      .pending         (pending),
      .refused_count   (refused_count),
      .underflow_count (underflow_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // stall the result side about a quarter of the time, never while steady
   always @(posedge clock) begin
      rsp_tready <= steady || ($urandom_range(0, 99) >= 26);
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t: no beat for %0d cycles, giving up", $time, quiet_cycles);
         $display("Regression FAIL");
         $finish;
      end
   end

   // Present one item and hold it until accepted; leave tvalid high afterward.
   task automatic send_item(input logic kind, input logic [KEY_W-1:0] key);
      if (!steady) begin
         while ($urandom_range(0, 99) < 26) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {1'b0, key};
      do @(posedge clock); while (!req_tready);
      if (kind == KIND_INSERT) inserts_sent++;
      else pops_sent++;
   endtask

   // Mix tight key ranges (many duplicates) with extremes and full-range keys.
   function automatic logic [KEY_W-1:0] random_key();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return KEY_W'($urandom_range(0, 7));
         4:          return $urandom_range(0, 1) ? '1 : '0;
         default:    return KEY_W'($urandom());
      endcase
   endfunction

   initial begin
      int   insert_pct;
      logic kind;
      insert_pct = 50;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // pop while empty, extremes, duplicates, fill up, refused insert
      send_item(KIND_POP, '1);
      send_item(KIND_INSERT, '1);
      send_item(KIND_INSERT, '0);
      send_item(KIND_INSERT, KEY_W'(5));
      send_item(KIND_INSERT, KEY_W'(5));
      send_item(KIND_INSERT, KEY_W'(5));
      send_item(KIND_POP, KEY_W'(31'h5555_5555));
      for (int n = 0; n < 12; n++) send_item(KIND_INSERT, KEY_W'(1000 - n * 50));
      send_item(KIND_INSERT, KEY_W'(1));
      send_item(KIND_INSERT, '1);
      send_item(KIND_POP, KEY_W'(31'h2AAA_AAAA));

      // random part: segments lean toward filling, draining or balance
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 40 == 0) begin
            case ($urandom_range(0, 2))
               0:       insert_pct = 15;
               1:       insert_pct = 50;
               default: insert_pct = 85;
            endcase
         end
         steady = (n >= 400 && n < 600);
         kind   = ($urandom_range(0, 99) < insert_pct) ? KIND_INSERT : KIND_POP;
         send_item(kind, random_key());
      end
      req_tvalid <= 1'b0;
      steady = 1'b0;

      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("Sent %0d inserts and %0d pops; %0d inserts refused on a full queue,",
               inserts_sent, pops_sent, refused_count);
      $display("%0d pops on an empty queue, %0d mismatches.", underflow_count, fail_count);
      if (fail_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
